// ----- rtl/core/ubx_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the UBX frame receiver.
// No dependencies; ubx_cfg_regs, ubx_parser and ubx_frame_receiver import this package.
package ubx_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECT_CLASS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECT_ID    = 2'd2;

    localparam logic [15:0] RST_MAX_LEN      = 16'd96;
    localparam logic [7:0]  RST_EXPECT_CLASS = 8'd6;
    localparam logic [7:0]  RST_EXPECT_ID    = 8'd62;

    localparam logic [7:0] SYNC_FIRST    = 8'hB5;
    localparam logic [7:0] SYNC_SECOND   = 8'h62;
    localparam logic [7:0] CLASS_ACK_NAK = 8'h05;
    localparam logic [7:0] ACK_ID_ACK    = 8'h01;
    localparam logic [7:0] ACK_ID_NAK    = 8'h00;
    localparam logic [15:0] ACK_LEN      = 16'd2;

    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_PAYLOAD = 3'd1;
    localparam logic [2:0] EV_GOOD    = 3'd2;
    localparam logic [2:0] EV_BAD     = 3'd3;
    localparam logic [2:0] EV_LONG    = 3'd4;

    localparam logic [1:0] ACK_NONE = 2'd0;
    localparam logic [1:0] ACK_ACK  = 2'd1;
    localparam logic [1:0] ACK_NAK  = 2'd2;

    typedef struct packed {
        logic [15:0] max_len;
        logic [7:0]  expect_class;
        logic [7:0]  expect_id;
    } t_ubx_cfg;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
        logic [7:0]  hdr_class;
        logic [7:0]  msg_id;
        logic [15:0] hdr_len;
        logic [1:0]  ack_status;
    } t_ubx_res;

endpackage

// ----- rtl/core/ubx_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for received bytes and parser results.
// Depends on nothing but the widths of the fields they carry.
interface ubx_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ubx_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [7:0]  hdr_class;
    logic [7:0]  msg_id;
    logic [15:0] hdr_len;
    logic [1:0]  ack_status;

    modport source (output valid, output event_res, output data_byte, output byte_index,
                    output hdr_class, output msg_id, output hdr_len,
                    output ack_status, input ready);
    modport sink   (input valid, input event_res, input data_byte, input byte_index,
                    input hdr_class, input msg_id, input hdr_len,
                    input ack_status, output ready);
endinterface

// ----- rtl/core/ubx_cfg_regs.sv -----
`timescale 1ns / 1ps
// Configuration register file of the UBX frame receiver.
// Depends on ubx_pkg for the register indexes and reset values.
module ubx_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ubx_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ubx_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output ubx_pkg::t_ubx_cfg             o_cfg
);
    import ubx_pkg::*;

    t_ubx_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_len      <= RST_MAX_LEN;
            r_cfg.expect_class <= RST_EXPECT_CLASS;
            r_cfg.expect_id    <= RST_EXPECT_ID;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_LEN:      r_cfg.max_len      <= i_cfg_data;
                CFG_EXPECT_CLASS: r_cfg.expect_class <= i_cfg_data[7:0];
                CFG_EXPECT_ID:    r_cfg.expect_id    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/core/ubx_parser.sv -----
`timescale 1ns / 1ps
// Frame state machine and 8-bit Fletcher checksum (two 8-bit sums, modulo 256) of the UBX frame receiver.
// Depends on ubx_pkg; the result is combinational and registered by the top level.
module ubx_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [7:0]        i_byte,
    input  ubx_pkg::t_ubx_cfg i_cfg,
    output ubx_pkg::t_ubx_res o_res
);
    import ubx_pkg::*;

    typedef enum logic [3:0] {
        PH_SYNC1   = 4'd0,
        PH_SYNC2   = 4'd1,
        PH_CLASS   = 4'd2,
        PH_ID      = 4'd3,
        PH_LEN_LO  = 4'd4,
        PH_LEN_HI  = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CK_A    = 4'd7,
        PH_CK_B    = 4'd8
    } t_phase;

    t_phase      r_phase,      n_phase;
    logic [7:0]  r_class,      n_class;
    logic [7:0]  r_id,         n_id;
    logic [15:0] r_len,        n_len;
    logic [15:0] r_pay_count,  n_pay_count;
    logic [7:0]  r_sum_a,      n_sum_a;
    logic [7:0]  r_sum_b,      n_sum_b;
    logic [7:0]  r_got_a,      n_got_a;
    logic [7:0]  r_first_pay,  n_first_pay;
    logic [7:0]  r_second_pay, n_second_pay;

    // Running sums after adding the current byte.
    logic [7:0] w_add_a;
    logic [7:0] w_add_b;
    assign w_add_a = r_sum_a + i_byte;
    assign w_add_b = r_sum_b + w_add_a;

    always_comb begin
        n_phase      = r_phase;
        n_class      = r_class;
        n_id         = r_id;
        n_len        = r_len;
        n_pay_count  = r_pay_count;
        n_sum_a      = r_sum_a;
        n_sum_b      = r_sum_b;
        n_got_a      = r_got_a;
        n_first_pay  = r_first_pay;
        n_second_pay = r_second_pay;
        o_res        = '0;

        case (r_phase)
            PH_SYNC1: begin
                n_phase = (i_byte == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
            end
            PH_SYNC2: begin
                n_phase = (i_byte == SYNC_SECOND) ? PH_CLASS : PH_SYNC1;
            end
            PH_CLASS: begin
                // The class byte starts a fresh checksum.
                n_class = i_byte;
                n_sum_a = i_byte;
                n_sum_b = i_byte;
                n_phase = PH_ID;
            end
            PH_ID: begin
                n_id    = i_byte;
                n_sum_a = w_add_a;
                n_sum_b = w_add_b;
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_len   = {8'h00, i_byte};
                n_sum_a = w_add_a;
                n_sum_b = w_add_b;
                n_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_len        = {i_byte, r_len[7:0]};
                n_sum_a      = w_add_a;
                n_sum_b      = w_add_b;
                n_pay_count  = '0;
                n_first_pay  = '0;
                n_second_pay = '0;
                if (n_len > i_cfg.max_len) begin
                    o_res.event_res = EV_LONG;
                    o_res.hdr_class = r_class;
                    o_res.msg_id    = r_id;
                    o_res.hdr_len   = n_len;
                    n_phase         = PH_SYNC1;
                end else if (n_len == '0) begin
                    n_phase = PH_CK_A;
                end else begin
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                o_res.event_res  = EV_PAYLOAD;
                o_res.data_byte  = i_byte;
                o_res.byte_index = r_pay_count;
                o_res.hdr_class  = r_class;
                o_res.msg_id     = r_id;
                o_res.hdr_len    = r_len;
                if (r_pay_count == 16'd0) begin
                    n_first_pay = i_byte;
                end else if (r_pay_count == 16'd1) begin
                    n_second_pay = i_byte;
                end
                n_sum_a     = w_add_a;
                n_sum_b     = w_add_b;
                n_pay_count = r_pay_count + 16'd1;
                if (n_pay_count >= r_len) begin
                    n_phase = PH_CK_A;
                end
            end
            PH_CK_A: begin
                n_got_a = i_byte;
                n_phase = PH_CK_B;
            end
            PH_CK_B: begin
                o_res.hdr_class = r_class;
                o_res.msg_id    = r_id;
                o_res.hdr_len   = r_len;
                if (r_got_a == r_sum_a && i_byte == r_sum_b) begin
                    o_res.event_res = EV_GOOD;
                    if (r_class == CLASS_ACK_NAK && r_len == ACK_LEN &&
                        r_first_pay == i_cfg.expect_class &&
                        r_second_pay == i_cfg.expect_id) begin
                        if (r_id == ACK_ID_ACK) begin
                            o_res.ack_status = ACK_ACK;
                        end else if (r_id == ACK_ID_NAK) begin
                            o_res.ack_status = ACK_NAK;
                        end
                    end
                end else begin
                    o_res.event_res = EV_BAD;
                end
                n_phase = PH_SYNC1;
            end
            default: begin
                n_phase = PH_SYNC1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SYNC1;
            r_class      <= '0;
            r_id         <= '0;
            r_len        <= '0;
            r_pay_count  <= '0;
            r_sum_a      <= '0;
            r_sum_b      <= '0;
            r_got_a      <= '0;
            r_first_pay  <= '0;
            r_second_pay <= '0;
        end else if (i_en) begin
            r_phase      <= n_phase;
            r_class      <= n_class;
            r_id         <= n_id;
            r_len        <= n_len;
            r_pay_count  <= n_pay_count;
            r_sum_a      <= n_sum_a;
            r_sum_b      <= n_sum_b;
            r_got_a      <= n_got_a;
            r_first_pay  <= n_first_pay;
            r_second_pay <= n_second_pay;
        end
    end

endmodule

// ----- rtl/core/ubx_frame_receiver.sv -----
`timescale 1ns / 1ps
// UBX frame receiver. Every accepted byte gives exactly one result, in order: a payload
// byte with its index, a good or bad checksum report at frame end, a too-long report,
// or an empty event for sync, header and first checksum bytes. A byte is taken into an
// input register, goes through the frame state machine and the 8-bit Fletcher update,
// and lands in the result register; its result is presented once both the input and the
// result register have taken it, and one byte per cycle is sustained while the result
// side does not stall. The frame state machine updates its state once per byte, which
// sets that rate, and both registers hold their contents while the result side stalls.
// Depends on ubx_pkg, ubx_if, ubx_cfg_regs and ubx_parser.
module ubx_frame_receiver (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ubx_rx_if.sink                        i_rx_ch,
    ubx_res_if.source                     o_res_ch,
    input  logic                          i_cfg_we,
    input  logic [ubx_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ubx_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ubx_pkg::*;

    t_ubx_cfg   w_cfg;
    t_ubx_res   w_res;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_ubx_res   r_out;
    logic       w_advance;

    // The middle stage moves whenever the result register is free or being emptied.
    assign w_advance      = !r_out_valid || o_res_ch.ready;
    assign i_rx_ch.ready  = !r_in_valid || w_advance;

    ubx_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    ubx_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (r_in_valid && w_advance),
        .i_byte  (r_in_byte),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_rx_ch.ready) begin
                r_in_valid <= i_rx_ch.valid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx_ch.valid && i_rx_ch.ready) begin
            r_in_byte <= i_rx_ch.rx_byte;
        end
        if (r_in_valid && w_advance) begin
            r_out <= w_res;
        end
    end

    assign o_res_ch.valid      = r_out_valid;
    assign o_res_ch.event_res  = r_out.event_res;
    assign o_res_ch.data_byte  = r_out.data_byte;
    assign o_res_ch.byte_index = r_out.byte_index;
    assign o_res_ch.hdr_class  = r_out.hdr_class;
    assign o_res_ch.msg_id     = r_out.msg_id;
    assign o_res_ch.hdr_len    = r_out.hdr_len;
    assign o_res_ch.ack_status = r_out.ack_status;

    // A full input register behind a stalled result must block new requests.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !o_res_ch.ready) |-> !i_rx_ch.ready)
        else $error("input accepted while both stages are full and stalled");

    // A held byte stays in the input register until the parser consumes it.
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("input byte lost while the result side stalled");

    // Acknowledge status only accompanies a good frame.
    a_ack_on_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.ack_status != ACK_NONE) |-> (r_out.event_res == EV_GOOD))
        else $error("acknowledge status reported without a good frame");

    // A payload byte index always lies inside the declared length.
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.event_res == EV_PAYLOAD) |->
            (r_out.byte_index < r_out.hdr_len))
        else $error("payload byte index beyond declared length");

endmodule
